FILE: design/shs_pkg.sv
// Shared types and constants for the shingle simhash fingerprint block.
// No dependencies.
package shs_pkg;

    localparam int unsigned MAX_SHINGLE_DEF = 16;
    localparam int unsigned VOTE_BITS_DEF   = 32;

    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    // FNV prime is 2^40 + FNV_PRIME_LO
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int unsigned FNV_SHIFT    = 40;

    localparam logic [4:0] SHINGLE_RESET = 5'd4;

    // one classified byte moving from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       keep;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_VOTE,
        S_FINAL,
        S_EMIT
    } back_state_t;

    // one FNV-1a step: (h ^ c) * prime, modulo 2^64
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] c);
        logic [63:0] x;
        logic [63:0] lo;
        x  = h ^ {56'd0, c};
        lo = x * {55'd0, FNV_PRIME_LO};
        return (x << FNV_SHIFT) + lo;
    endfunction

endpackage

FILE: design/shs_front.sv
// Front end: accepts text bytes, cleans and lowercases them, tracks end of content.
// Depends on shs_pkg.
module shs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              in_stall,
    output logic              q_push,
    output shs_pkg::item_t    q_item
);

    logic ended_reg;
    logic ended_next;
    logic is_upper;
    logic is_lower;
    logic is_digit;
    logic is_space;

    // classify
    always_comb
    begin
        is_upper = (text_byte >= 8'h41) && (text_byte <= 8'h5A);
        is_lower = (text_byte >= 8'h61) && (text_byte <= 8'h7A);
        is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        is_space = (text_byte == 8'h20) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
        in_stall = q_full;
        q_push   = in_valid && !q_full;
        q_item.ch   = is_upper ? (text_byte + 8'd32) : text_byte;
        q_item.keep = !ended_reg && (text_byte != 8'd0) &&
                      (is_upper || is_lower || is_digit || is_space);
        q_item.last = end_of_text;
    end

    // content ends at a zero byte until the text closes
    always_comb
    begin
        ended_next = ended_reg;
        if (q_push)
        begin
            if (end_of_text)
                ended_next = 1'b0;
            else if (text_byte == 8'd0)
                ended_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ended_reg <= 1'b0;
        else
            ended_reg <= ended_next;
    end

endmodule

FILE: design/shs_queue.sv
// Two-entry request queue between front and back.
// Depends on shs_pkg.
module shs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  shs_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output shs_pkg::item_t head
);

    shs_pkg::item_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: design/shs_back.sv
// Back end: shingle window, iterative FNV-1a hash, vote counters, result register.
// Depends on shs_pkg.
module shs_back
#(
    parameter int unsigned MAX_SHINGLE = shs_pkg::MAX_SHINGLE_DEF,
    parameter int unsigned VOTE_BITS   = shs_pkg::VOTE_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [4:0]     win_size,
    input  logic           q_valid,
    input  shs_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [63:0]    fingerprint
);

    localparam int unsigned KW = $clog2(MAX_SHINGLE + 1);
    localparam int unsigned IW = (MAX_SHINGLE > 1) ? $clog2(MAX_SHINGLE) : 1;
    localparam logic signed [VOTE_BITS-1:0] VTOP = {1'b0, {(VOTE_BITS-1){1'b1}}};
    localparam logic signed [VOTE_BITS-1:0] VBOT = {1'b1, {(VOTE_BITS-1){1'b0}}};
    localparam logic signed [VOTE_BITS-1:0] VONE = {{(VOTE_BITS-1){1'b0}}, 1'b1};

    shs_pkg::back_state_t state_reg, state_next;

    logic [7:0]  win_reg [MAX_SHINGLE];
    logic [KW-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [KW-1:0] n_reg, n_next;
    logic [KW-1:0] i_reg, i_next;
    logic [63:0] h_reg, h_next;
    logic        last_reg, last_next;
    logic        tail_reg, tail_next;
    logic signed [VOTE_BITS-1:0] votes_reg [64];
    logic        out_valid_reg;
    logic [63:0] fp_reg;
    logic [KW-1:0] k_eff;
    logic [KW:0]  rd_sum;
    logic [IW-1:0] rd_idx;
    logic        shift_en;
    logic        vote_en;
    logic        emit_en;
    logic        out_free;
    logic [63:0] fp_now;

    // effective shingle size: zero acts as one, saturate at MAX_SHINGLE
    always_comb
    begin
        if (win_size == 5'd0)
            k_eff = KW'(1);
        else if (32'(win_size) > MAX_SHINGLE)
            k_eff = KW'(MAX_SHINGLE);
        else
            k_eff = KW'(win_size);
    end

    assign cnt_inc  = (32'(cnt_reg) < MAX_SHINGLE) ? (cnt_reg + KW'(1)) : cnt_reg;
    assign rd_sum   = (KW+1)'(MAX_SHINGLE) - {1'b0, n_reg} + {1'b0, i_reg};
    assign rd_idx   = rd_sum[IW-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    // fingerprint from current vote counters
    always_comb
    begin
        for (int b = 0; b < 64; b++)
            fp_now[b] = (cnt_reg != '0) && (votes_reg[b] > 0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shs_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.keep && (cnt_inc >= k_eff))
                        state_next = shs_pkg::S_HASH;
                    else if (q_item.last)
                        state_next = shs_pkg::S_FINAL;
                end
            end
            shs_pkg::S_HASH:
            begin
                if (i_reg + KW'(1) == n_reg)
                    state_next = shs_pkg::S_VOTE;
            end
            shs_pkg::S_VOTE:
            begin
                if (!last_reg)
                    state_next = shs_pkg::S_IDLE;
                else if (tail_reg)
                    state_next = shs_pkg::S_EMIT;
                else
                    state_next = shs_pkg::S_FINAL;
            end
            shs_pkg::S_FINAL:
            begin
                if ((cnt_reg != '0) && (cnt_reg < k_eff))
                    state_next = shs_pkg::S_HASH;
                else
                    state_next = shs_pkg::S_EMIT;
            end
            shs_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = shs_pkg::S_IDLE;
            end
            default: state_next = shs_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        q_pop     = 1'b0;
        shift_en  = 1'b0;
        vote_en   = 1'b0;
        emit_en   = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        i_next    = i_reg;
        h_next    = h_reg;
        last_next = last_reg;
        tail_next = tail_reg;
        case (state_reg)
            shs_pkg::S_IDLE:
            begin
                q_pop     = q_valid;
                last_next = q_item.last;
                tail_next = 1'b0;
                i_next    = '0;
                h_next    = shs_pkg::FNV_BASIS;
                n_next    = k_eff;
                if (q_valid && q_item.keep)
                begin
                    shift_en = 1'b1;
                    cnt_next = cnt_inc;
                end
            end
            shs_pkg::S_HASH:
            begin
                h_next = shs_pkg::fnv_step(h_reg, win_reg[rd_idx]);
                i_next = i_reg + KW'(1);
            end
            shs_pkg::S_VOTE:
            begin
                vote_en = 1'b1;
            end
            shs_pkg::S_FINAL:
            begin
                tail_next = 1'b1;
                n_next    = cnt_reg;
                i_next    = '0;
                h_next    = shs_pkg::FNV_BASIS;
            end
            shs_pkg::S_EMIT:
            begin
                emit_en = out_free;
                if (out_free)
                    cnt_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shs_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            tail_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            tail_reg  <= tail_next;
            if (emit_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        i_reg <= i_next;
        h_reg <= h_next;
        if (emit_en)
            fp_reg <= fp_now;
        if (shift_en)
        begin
            for (int j = 0; j < MAX_SHINGLE - 1; j++)
                win_reg[j] <= win_reg[j+1];
            win_reg[MAX_SHINGLE-1] <= q_item.ch;
        end
    end

    // vote counters, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 64; b++)
                votes_reg[b] <= '0;
        end
        else if (emit_en)
        begin
            for (int b = 0; b < 64; b++)
                votes_reg[b] <= '0;
        end
        else if (vote_en)
        begin
            for (int b = 0; b < 64; b++)
            begin
                if (h_reg[b])
                begin
                    if (votes_reg[b] != VTOP)
                        votes_reg[b] <= votes_reg[b] + VONE;
                end
                else if (votes_reg[b] != VBOT)
                    votes_reg[b] <= votes_reg[b] - VONE;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign fingerprint = fp_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_SHINGLE) else $error("kept count beyond window");
    a_hash_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shs_pkg::S_HASH) |-> (n_reg != '0) && (i_reg < n_reg))
        else $error("hash length invalid");
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == shs_pkg::S_EMIT))
        else $error("result without emit");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == shs_pkg::S_IDLE)) else $error("pop while busy");
`endif

endmodule

FILE: design/shingle_simhash_fingerprint.sv
// A byte that completes a window holds the back end while it hashes (k = shingle
// size, one FNV-1a step per cycle on a shared multiply unit) and votes, and no new byte
// is taken meanwhile. After end of text the fingerprint is registered in the emit state.
// Throughput is set by the hash loop; a 2-entry queue decouples input from it.
// Reset clears control, vote counters and sets the shingle size to 4.
// Top level; depends on shs_pkg, shs_front, shs_queue, shs_back.
module shingle_simhash_fingerprint
#(
    parameter int unsigned MAX_SHINGLE = shs_pkg::MAX_SHINGLE_DEF,
    parameter int unsigned VOTE_BITS   = shs_pkg::VOTE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] fingerprint
);

    logic [4:0]     shingle_reg;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    shs_pkg::item_t push_item;
    shs_pkg::item_t head_item;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shingle_reg <= shs_pkg::SHINGLE_RESET;
        else if (cfg_we)
            shingle_reg <= cfg_wdata;
    end

    shs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .in_stall    (in_stall),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    shs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_item)
    );

    shs_back
    #(
        .MAX_SHINGLE (MAX_SHINGLE),
        .VOTE_BITS   (VOTE_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .win_size     (shingle_reg),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fingerprint  (fingerprint)
    );

endmodule
